/* rtl/ffa_pkg.sv */
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared constants and types for the first-fit page region allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ffa_pkg;

    localparam int MAX_REGIONS = 256;
    localparam int PAGE_SHIFT  = 12;

    localparam int ADDR_W = 64;
    localparam int PAGE_W = 52;
    localparam int KIND_W = 4;
    localparam int OP_W   = 2;
    localparam int STAT_W = 3;

    localparam int SLOT_W = $clog2(MAX_REGIONS);
    localparam int LINK_W = SLOT_W + 1;

    localparam logic [LINK_W-1:0] NONE = LINK_W'(MAX_REGIONS);

    localparam logic [KIND_W-1:0] FREE_KIND = 4'd0;
    localparam logic [KIND_W-1:0] USED_KIND = 4'd8;

    localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_NO_FIT   = 3'd1;
    localparam logic [STAT_W-1:0] ST_NOT_USED = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOT_FND  = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd4;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [PAGE_W-1:0] pages;
        logic [KIND_W-1:0] kind;
        logic [LINK_W-1:0] next;
        logic [LINK_W-1:0] prev;
    } region_t;

    typedef struct packed {
        logic start;
        logic pages;
        logic kind;
        logic next;
        logic prev;
    } region_we_t;

    typedef struct packed {
        logic              pop;
        logic              push;
        logic [SLOT_W-1:0] slot;
    } stk_ctl_t;

endpackage

`default_nettype wire

/* rtl/ffa_req_if.sv */
// ----------------------------------------------------------------------------
// ffa_req_if
// Request channel: valid/ready handshake with the operation payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ffa_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [63:0] base_address;
    logic [63:0] length_bytes;
    logic [51:0] page_count;
    logic [3:0]  region_type;

    modport source (output valid, operation, base_address, length_bytes, page_count,
                    region_type, input ready);
    modport sink   (input valid, operation, base_address, length_bytes, page_count,
                    region_type, output ready);
endinterface

`default_nettype wire

/* rtl/ffa_rsp_if.sv */
// ----------------------------------------------------------------------------
// ffa_rsp_if
// Response channel: valid/ready handshake with address and status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ffa_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] address;
    logic [2:0]  status;

    modport source (output valid, address, status, input ready);
    modport sink   (input valid, address, status, output ready);
endinterface

`default_nettype wire

/* rtl/ffa_region_ram.sv */
// ----------------------------------------------------------------------------
// ffa_region_ram
// Region table: one write port with per-field enables, one registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ffa_region_ram (
    input  wire logic                      clk,
    input  wire logic [ffa_pkg::SLOT_W-1:0] rd_addr,
    output ffa_pkg::region_t               rd_data,
    input  wire logic [ffa_pkg::SLOT_W-1:0] wr_addr,
    input  wire ffa_pkg::region_we_t       wr_en,
    input  wire ffa_pkg::region_t          wr_data
);
    import ffa_pkg::*;

    logic [ADDR_W-1:0] start_mem [MAX_REGIONS];
    logic [PAGE_W-1:0] pages_mem [MAX_REGIONS];
    logic [KIND_W-1:0] kind_mem  [MAX_REGIONS];
    logic [LINK_W-1:0] next_mem  [MAX_REGIONS];
    logic [LINK_W-1:0] prev_mem  [MAX_REGIONS];

    always_ff @(posedge clk)
    begin
        if (wr_en.start) start_mem[wr_addr] <= wr_data.start;
        if (wr_en.pages) pages_mem[wr_addr] <= wr_data.pages;
        if (wr_en.kind)  kind_mem[wr_addr]  <= wr_data.kind;
        if (wr_en.next)  next_mem[wr_addr]  <= wr_data.next;
        if (wr_en.prev)  prev_mem[wr_addr]  <= wr_data.prev;
        rd_data.start <= start_mem[rd_addr];
        rd_data.pages <= pages_mem[rd_addr];
        rd_data.kind  <= kind_mem[rd_addr];
        rd_data.next  <= next_mem[rd_addr];
        rd_data.prev  <= prev_mem[rd_addr];
    end

endmodule

`default_nettype wire

/* rtl/ffa_spare_stack.sv */
// ----------------------------------------------------------------------------
// ffa_spare_stack
// Stack of unused slot numbers. Entries below the low-water mark were never
// overwritten and read as their reset value; top is valid in the cycle after
// the count settles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ffa_spare_stack (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire ffa_pkg::stk_ctl_t          ctl,
    output logic [ffa_pkg::LINK_W-1:0]      count,
    output logic [ffa_pkg::SLOT_W-1:0]      top
);
    import ffa_pkg::*;

    logic [SLOT_W-1:0] mem [MAX_REGIONS];
    logic [LINK_W-1:0] count_reg, count_next;
    logic [LINK_W-1:0] low_reg, low_next;
    logic [LINK_W-1:0] count_dec;
    logic [SLOT_W-1:0] top_idx;
    logic [SLOT_W-1:0] data_reg;
    logic [SLOT_W-1:0] init_reg;
    logic              below_reg;

    assign count_dec = count_reg - LINK_W'(1);
    assign top_idx   = count_dec[SLOT_W-1:0];

    always_comb
    begin
        count_next = count_reg;
        low_next   = low_reg;
        if (ctl.pop)
        begin
            count_next = count_dec;
            if (count_dec < low_reg)
                low_next = count_dec;
        end
        else if (ctl.push)
        begin
            count_next = count_reg + LINK_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= LINK_W'(MAX_REGIONS);
            low_reg   <= LINK_W'(MAX_REGIONS);
        end
        else
        begin
            count_reg <= count_next;
            low_reg   <= low_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push)
            mem[count_reg[SLOT_W-1:0]] <= ctl.slot;
        data_reg  <= mem[top_idx];
        init_reg  <= SLOT_W'(MAX_REGIONS - 1) - top_idx;
        below_reg <= {1'b0, top_idx} < low_reg;
    end

    assign count = count_reg;
    assign top   = below_reg ? init_reg : data_reg;

endmodule

`default_nettype wire

/* rtl/first_fit_page_region_allocator_core.sv */
// ----------------------------------------------------------------------------
// first_fit_page_region_allocator_core
// First-fit page region allocator over a linked region table in RAM.
//
//   channel | dir | payload
//   --------+-----+------------------------------------------------------
//   req     | in  | operation, base_address, length_bytes, page_count,
//           |     | region_type
//   rsp     | out | address, status
//
// One request at a time. Add writes the new entry, then links any old tail.
// Allocate and free walk the list one entry per cycle through the region
// RAM read port, then split, merge and relink entries. No clearing pass
// after reset. The response register holds a result while the next request
// is accepted; a stalled rsp holds the engine in RESP.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module first_fit_page_region_allocator_core (
    input  wire logic clk,
    input  wire logic rst_n,
    ffa_req_if.sink   req,
    ffa_rsp_if.source rsp
);
    import ffa_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_ADD       = 9'b000000010,
        S_ADD_LINK  = 9'b000000100,
        S_WALK      = 9'b000001000,
        S_SPLIT1    = 9'b000010000,
        S_SPLIT2    = 9'b000100000,
        S_FREE_PRED = 9'b001000000,
        S_FIX       = 9'b010000000,
        S_RESP      = 9'b100000000
    } state_t;

    state_t            state_reg, state_next;
    logic [LINK_W-1:0] head_reg, head_next;
    logic [LINK_W-1:0] tail_reg, tail_next;
    logic              rsp_valid_reg, rsp_valid_next;
    logic [ADDR_W-1:0] rsp_addr_reg, rsp_addr_next;
    logic [STAT_W-1:0] rsp_status_reg, rsp_status_next;

    logic [OP_W-1:0]   op_reg, op_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic [PAGE_W-1:0] len_pages_reg, len_pages_next;
    logic [PAGE_W-1:0] cnt_reg, cnt_next;
    logic [KIND_W-1:0] type_reg, type_next;
    logic [SLOT_W-1:0] cur_reg, cur_next;
    logic [LINK_W-1:0] after_reg, after_next;
    logic [LINK_W-1:0] link_reg, link_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [ADDR_W-1:0] start_cur_reg, start_cur_next;
    logic [PAGE_W-1:0] pages_cur_reg, pages_cur_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [STAT_W-1:0] status_reg, status_next;

    logic [SLOT_W-1:0] rd_addr;
    region_t           rd;
    logic [SLOT_W-1:0] wr_addr;
    region_we_t        wr_en;
    region_t           wr_data;
    stk_ctl_t          stk;
    logic [LINK_W-1:0] stk_count;
    logic [SLOT_W-1:0] stk_top;

    logic [ADDR_W-1:0] len_shifted;
    logic [ADDR_W-1:0] split_end;
    logic [ADDR_W-1:0] pred_end;

    ffa_region_ram u_ram (
        .clk     (clk),
        .rd_addr (rd_addr),
        .rd_data (rd),
        .wr_addr (wr_addr),
        .wr_en   (wr_en),
        .wr_data (wr_data)
    );

    ffa_spare_stack u_stack (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (stk),
        .count (stk_count),
        .top   (stk_top)
    );

    assign len_shifted = req.length_bytes >> PAGE_SHIFT;
    assign split_end   = start_cur_reg + (ADDR_W'(pages_cur_reg) << PAGE_SHIFT);
    assign pred_end    = rd.start + (ADDR_W'(rd.pages) << PAGE_SHIFT);

    assign req.ready  = (state_reg == S_IDLE);
    assign rsp.valid  = rsp_valid_reg;
    assign rsp.address = rsp_addr_reg;
    assign rsp.status = rsp_status_reg;

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        op_next         = op_reg;
        base_next       = base_reg;
        len_pages_next  = len_pages_reg;
        cnt_next        = cnt_reg;
        type_next       = type_reg;
        cur_next        = cur_reg;
        after_next      = after_reg;
        link_next       = link_reg;
        slot_next       = slot_reg;
        start_cur_next  = start_cur_reg;
        pages_cur_next  = pages_cur_reg;
        addr_next       = addr_reg;
        status_next     = status_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_addr_next   = rsp_addr_reg;
        rsp_status_next = rsp_status_reg;
        rd_addr         = cur_reg;
        wr_addr         = cur_reg;
        wr_en           = '0;
        wr_data         = '0;
        stk             = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next        = req.operation;
                    base_next      = req.base_address;
                    len_pages_next = len_shifted[PAGE_W-1:0];
                    cnt_next       = req.page_count;
                    type_next      = req.region_type;
                    addr_next      = '0;
                    status_next    = ST_OK;
                    state_next     = S_RESP;
                    case (req.operation)
                        OP_ADD:
                        begin
                            if (stk_count == '0)
                                status_next = ST_FULL;
                            else
                                state_next = S_ADD;
                        end
                        OP_ALLOC, OP_FREE:
                        begin
                            if (head_reg == NONE)
                            begin
                                status_next = (req.operation == OP_ALLOC) ?
                                              ST_NO_FIT : ST_NOT_FND;
                            end
                            else
                            begin
                                rd_addr    = head_reg[SLOT_W-1:0];
                                cur_next   = head_reg[SLOT_W-1:0];
                                state_next = S_WALK;
                            end
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end

            S_ADD:
            begin
                wr_addr       = stk_top;
                wr_en         = '1;
                wr_data.start = base_reg;
                wr_data.pages = len_pages_reg;
                wr_data.kind  = type_reg;
                wr_data.next  = NONE;
                wr_data.prev  = tail_reg;
                stk.pop       = 1'b1;
                slot_next     = stk_top;
                link_next     = tail_reg;
                tail_next     = {1'b0, stk_top};
                if (tail_reg == NONE)
                begin
                    head_next  = {1'b0, stk_top};
                    state_next = S_RESP;
                end
                else
                begin
                    state_next = S_ADD_LINK;
                end
            end

            S_ADD_LINK:
            begin
                wr_addr      = link_reg[SLOT_W-1:0];
                wr_en.next   = 1'b1;
                wr_data.next = {1'b0, slot_reg};
                state_next   = S_RESP;
            end

            S_WALK:
            begin
                if (op_reg == OP_ALLOC)
                begin
                    if (rd.kind == FREE_KIND && rd.pages == cnt_reg)
                    begin
                        wr_en.kind   = 1'b1;
                        wr_data.kind = USED_KIND;
                        addr_next    = rd.start;
                        state_next   = S_RESP;
                    end
                    else if (rd.kind == FREE_KIND && rd.pages > cnt_reg)
                    begin
                        if (stk_count == '0)
                        begin
                            status_next = ST_FULL;
                            state_next  = S_RESP;
                        end
                        else
                        begin
                            pages_cur_next = rd.pages - cnt_reg;
                            start_cur_next = rd.start;
                            after_next     = rd.next;
                            state_next     = S_SPLIT1;
                        end
                    end
                    else if (rd.next == NONE)
                    begin
                        status_next = ST_NO_FIT;
                        state_next  = S_RESP;
                    end
                    else
                    begin
                        rd_addr  = rd.next[SLOT_W-1:0];
                        cur_next = rd.next[SLOT_W-1:0];
                    end
                end
                else
                begin
                    if (rd.start == base_reg)
                    begin
                        if (rd.kind != USED_KIND)
                        begin
                            status_next = ST_NOT_USED;
                            state_next  = S_RESP;
                        end
                        else
                        begin
                            wr_en.kind   = 1'b1;
                            wr_data.kind = FREE_KIND;
                            if ({1'b0, cur_reg} == head_reg || rd.prev == NONE)
                            begin
                                state_next = S_RESP;
                            end
                            else
                            begin
                                rd_addr        = rd.prev[SLOT_W-1:0];
                                link_next      = rd.prev;
                                start_cur_next = rd.start;
                                pages_cur_next = rd.pages;
                                after_next     = rd.next;
                                state_next     = S_FREE_PRED;
                            end
                        end
                    end
                    else if (rd.next == NONE)
                    begin
                        status_next = ST_NOT_FND;
                        state_next  = S_RESP;
                    end
                    else
                    begin
                        rd_addr  = rd.next[SLOT_W-1:0];
                        cur_next = rd.next[SLOT_W-1:0];
                    end
                end
            end

            S_SPLIT1:
            begin
                wr_addr       = stk_top;
                wr_en         = '1;
                wr_data.start = split_end;
                wr_data.pages = cnt_reg;
                wr_data.kind  = USED_KIND;
                wr_data.next  = after_reg;
                wr_data.prev  = {1'b0, cur_reg};
                stk.pop       = 1'b1;
                slot_next     = stk_top;
                addr_next     = split_end;
                state_next    = S_SPLIT2;
            end

            S_SPLIT2:
            begin
                wr_en.next    = 1'b1;
                wr_en.pages   = 1'b1;
                wr_data.next  = {1'b0, slot_reg};
                wr_data.pages = pages_cur_reg;
                link_next     = {1'b0, slot_reg};
                state_next    = S_FIX;
            end

            S_FREE_PRED:
            begin
                if (rd.kind == FREE_KIND && pred_end == start_cur_reg)
                begin
                    wr_addr       = link_reg[SLOT_W-1:0];
                    wr_en.pages   = 1'b1;
                    wr_en.next    = 1'b1;
                    wr_data.pages = rd.pages + pages_cur_reg;
                    wr_data.next  = after_reg;
                    state_next    = S_FIX;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end

            S_FIX:
            begin
                if (after_reg != NONE)
                begin
                    wr_addr      = after_reg[SLOT_W-1:0];
                    wr_en.prev   = 1'b1;
                    wr_data.prev = link_reg;
                end
                else
                begin
                    tail_next = link_reg;
                end
                if (op_reg == OP_FREE)
                begin
                    stk.push = 1'b1;
                    stk.slot = cur_reg;
                end
                state_next = S_RESP;
            end

            S_RESP:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_addr_next   = addr_reg;
                    rsp_status_next = status_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= NONE;
            tail_reg      <= NONE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_addr_reg   <= rsp_addr_next;
        rsp_status_reg <= rsp_status_next;
        op_reg         <= op_next;
        base_reg       <= base_next;
        len_pages_reg  <= len_pages_next;
        cnt_reg        <= cnt_next;
        type_reg       <= type_next;
        cur_reg        <= cur_next;
        after_reg      <= after_next;
        link_reg       <= link_next;
        slot_reg       <= slot_next;
        start_cur_reg  <= start_cur_next;
        pages_cur_reg  <= pages_cur_next;
        addr_reg       <= addr_next;
        status_reg     <= status_next;
    end

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> rsp.status <= ST_FULL)
        else $error("response status out of range");

    a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status != ST_OK |-> rsp.address == '0)
        else $error("nonzero address on failed request");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> state_reg != S_IDLE)
        else $error("engine idle right after accepting a request");

    a_head_tail: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg == NONE) == (tail_reg == NONE))
        else $error("list head and tail disagree on empty");

endmodule

`default_nettype wire

/* sim/ffa_checker.sv */
// ----------------------------------------------------------------------------
// ffa_checker
// Watches the request and response channels, predicts each response from a
// private copy of the region table and compares address and status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffa_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_ready,
    input  logic [1:0]  req_operation,
    input  logic [63:0] req_base_address,
    input  logic [63:0] req_length_bytes,
    input  logic [51:0] req_page_count,
    input  logic [3:0]  req_region_type,
    input  logic        rsp_valid,
    input  logic        rsp_ready,
    input  logic [63:0] rsp_address,
    input  logic [2:0]  rsp_status,
    output int          errors,
    output int          pending
);
    import ffa_pkg::*;

    typedef struct packed {
        logic [63:0] address;
        logic [2:0]  status;
    } alloc_rsp_t;

    logic [63:0] tbl_start [MAX_REGIONS];
    logic [51:0] tbl_pages [MAX_REGIONS];
    logic [3:0]  tbl_kind  [MAX_REGIONS];
    int          tbl_next  [MAX_REGIONS];
    int          tbl_prev  [MAX_REGIONS];
    int          head_slot;
    int          tail_slot;
    int          spare_stack [MAX_REGIONS];
    int          spare_top;
    alloc_rsp_t  rsp_queue [$];

    function automatic logic [63:0] end_of(int s);
        return tbl_start[s] + ({12'd0, tbl_pages[s]} << PAGE_SHIFT);
    endfunction

    function automatic alloc_rsp_t predict(logic [1:0] op, logic [63:0] ba,
                                           logic [63:0] lb, logic [51:0] pc,
                                           logic [3:0] rt);
        alloc_rsp_t r;
        int cur;
        int n;
        int p;
        int after;
        int steps;
        r.address = '0;
        r.status  = ST_OK;
        if (op == OP_ADD) begin
            if (spare_top == 0) begin
                r.status = ST_FULL;
            end
            else begin
                spare_top--;
                n = spare_stack[spare_top];
                tbl_start[n] = ba;
                tbl_pages[n] = lb[63:12];
                tbl_kind[n]  = rt;
                tbl_next[n]  = MAX_REGIONS;
                tbl_prev[n]  = tail_slot;
                if (tail_slot < MAX_REGIONS)
                    tbl_next[tail_slot] = n;
                else
                    head_slot = n;
                tail_slot = n;
            end
        end
        else if (op == OP_ALLOC) begin
            r.status = ST_NO_FIT;
            cur = head_slot;
            for (steps = 0; cur < MAX_REGIONS && steps < MAX_REGIONS; steps++) begin
                if (tbl_kind[cur] == FREE_KIND && tbl_pages[cur] == pc) begin
                    tbl_kind[cur] = USED_KIND;
                    r.address = tbl_start[cur];
                    r.status  = ST_OK;
                    break;
                end
                if (tbl_kind[cur] == FREE_KIND && tbl_pages[cur] > pc) begin
                    if (spare_top == 0) begin
                        r.status = ST_FULL;
                        break;
                    end
                    spare_top--;
                    n = spare_stack[spare_top];
                    after = tbl_next[cur];
                    tbl_next[n] = after;
                    tbl_prev[n] = cur;
                    tbl_next[cur] = n;
                    if (after < MAX_REGIONS)
                        tbl_prev[after] = n;
                    else
                        tail_slot = n;
                    tbl_pages[cur] = tbl_pages[cur] - pc;
                    tbl_pages[n] = pc;
                    tbl_start[n] = end_of(cur);
                    tbl_kind[n] = USED_KIND;
                    r.address = tbl_start[n];
                    r.status  = ST_OK;
                    break;
                end
                cur = tbl_next[cur];
            end
        end
        else if (op == OP_FREE) begin
            cur = head_slot;
            for (steps = 0; cur < MAX_REGIONS && steps < MAX_REGIONS; steps++) begin
                if (tbl_start[cur] == ba)
                    break;
                cur = tbl_next[cur];
            end
            if (cur >= MAX_REGIONS || steps >= MAX_REGIONS) begin
                r.status = ST_NOT_FND;
            end
            else if (tbl_kind[cur] != USED_KIND) begin
                r.status = ST_NOT_USED;
            end
            else begin
                tbl_kind[cur] = FREE_KIND;
                p = tbl_prev[cur];
                if (cur != head_slot && p < MAX_REGIONS && tbl_kind[p] == FREE_KIND
                    && end_of(p) == tbl_start[cur]) begin
                    after = tbl_next[cur];
                    tbl_pages[p] = tbl_pages[p] + tbl_pages[cur];
                    tbl_next[p] = after;
                    if (after < MAX_REGIONS)
                        tbl_prev[after] = p;
                    else
                        tail_slot = p;
                    if (spare_top < MAX_REGIONS)
                    begin
                        spare_stack[spare_top] = cur;
                        spare_top++;
                    end
                end
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        alloc_rsp_t e;
        int         nerr;
        nerr = 0;
        if (!rst_n) begin
            errors  <= 0;
            pending <= 0;
            head_slot = MAX_REGIONS;
            tail_slot = MAX_REGIONS;
            spare_top = MAX_REGIONS;
            for (int i = 0; i < MAX_REGIONS; i++) begin
                spare_stack[i] = MAX_REGIONS - 1 - i;
                tbl_next[i] = MAX_REGIONS;
                tbl_prev[i] = MAX_REGIONS;
            end
            rsp_queue.delete();
        end
        else begin
            if (rsp_valid && rsp_ready) begin
                if (rsp_queue.size() == 0) begin
                    $error("unexpected response address=%h status=%0d",
                           rsp_address, rsp_status);
                    nerr++;
                end
                else begin
                    e = rsp_queue.pop_front();
                    if (rsp_address !== e.address) begin
                        $error("address expected %h actual %h", e.address, rsp_address);
                        nerr++;
                    end
                    if (rsp_status !== e.status) begin
                        $error("status expected %0d actual %0d", e.status, rsp_status);
                        nerr++;
                    end
                end
            end
            if (req_valid && req_ready)
                rsp_queue.push_back(predict(req_operation, req_base_address,
                                            req_length_bytes, req_page_count,
                                            req_region_type));
            errors  <= errors + nerr;
            pending <= rsp_queue.size();
        end
    end

endmodule

/* sim/first_fit_page_region_allocator_core_tb.sv */
// ----------------------------------------------------------------------------
// first_fit_page_region_allocator_core_tb
// Drives add, allocate, free and no-op requests with bursty traffic and a
// stalling response side; the checker predicts and compares every response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module first_fit_page_region_allocator_core_tb;
    import ffa_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    int   cycles = 0;
    int   burst_left;
    int   gap_left;
    logic [63:0] used_addrs [$];
    logic [63:0] seen_addrs [$];

    ffa_req_if req ();
    ffa_rsp_if rsp ();

    first_fit_page_region_allocator_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    ffa_checker chk (
        .clk              (clk),
        .rst_n            (rst_n),
        .req_valid        (req.valid),
        .req_ready        (req.ready),
        .req_operation    (req.operation),
        .req_base_address (req.base_address),
        .req_length_bytes (req.length_bytes),
        .req_page_count   (req.page_count),
        .req_region_type  (req.region_type),
        .rsp_valid        (rsp.valid),
        .rsp_ready        (rsp.ready),
        .rsp_address      (rsp.address),
        .rsp_status       (rsp.status),
        .errors           (errors),
        .pending          (pending)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver stall pattern: long clean stretches, then random stalls
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else if ((cycles / 500) % 3 == 0)
            rsp.ready <= 1'b1;
        else
            rsp.ready <= ($urandom_range(0, 3) != 0);
    end

    // capture allocated addresses so frees hit real regions
    always @(posedge clk) begin
        if (rst_n && rsp.valid && rsp.ready && rsp.status == ST_OK && rsp.address != 0)
            used_addrs.push_back(rsp.address);
    end

    task automatic send(logic [1:0] op, logic [63:0] ba, logic [63:0] lb,
                        logic [51:0] pc, logic [3:0] rt);
        if (burst_left == 0) begin
            gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 12);
            if (gap_left != 0) begin
                req.valid <= 1'b0;
                repeat (gap_left) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        req.valid        <= 1'b1;
        req.operation    <= op;
        req.base_address <= ba;
        req.length_bytes <= lb;
        req.page_count   <= pc;
        req.region_type  <= rt;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] pick_free_addr();
        int k;
        if (used_addrs.size() != 0 && $urandom_range(0, 9) < 8) begin
            k = $urandom_range(0, used_addrs.size() - 1);
            return used_addrs[k];
        end
        if (seen_addrs.size() != 0 && $urandom_range(0, 1) == 0)
            return seen_addrs[$urandom_range(0, seen_addrs.size() - 1)];
        return rand64();
    endfunction

    initial begin
        logic [63:0] b;
        int          r;
        rst_n            = 1'b0;
        burst_left       = 0;
        req.valid        = 1'b0;
        req.operation    = OP_ADD;
        req.base_address = '0;
        req.length_bytes = '0;
        req.page_count   = '0;
        req.region_type  = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed
        send(OP_FREE, 64'h1000, 0, 0, 0);
        send(OP_ALLOC, 0, 0, 0, 0);
        send(OP_ADD, 64'h10_0000, 64'h10_0FFF, 0, FREE_KIND);
        send(OP_ADD, 64'h20_0000, 64'h3000, 0, FREE_KIND);
        send(OP_ADD, 64'h30_0000, 64'h0, 0, FREE_KIND);
        send(OP_ADD, 64'hFFFF_FFFF_FFFF_F000, 64'hFFFF_FFFF_FFFF_FFFF, 0, 4'hF);
        send(OP_ADD, 64'h40_0000, 64'h8000, 0, USED_KIND);
        send(OP_ALLOC, 0, 0, 52'd0, 0);
        send(OP_ALLOC, 0, 0, 52'd0, 0);
        send(OP_ALLOC, 0, 0, 52'd3, 0);
        send(OP_ALLOC, 0, 0, 52'hF_FFFF_FFFF_FFFF, 0);
        send(OP_ALLOC, 0, 0, 52'd4, 0);
        send(OP_ALLOC, 0, 0, 52'd4, 0);
        send(OP_FREE, 64'h10_0000, 0, 0, 0);
        send(OP_FREE, 64'h20_0000, 0, 0, 0);
        send(OP_FREE, 64'h40_0000, 0, 0, 0);
        send(OP_FREE, 64'h40_0000, 0, 0, 0);
        send(OP_FREE, 64'h1234, 0, 0, 0);
        send(OP_NONE, rand64(), rand64(), 52'hF_FFFF_FFFF_FFFF, 4'hF);
        drain();

        // random: mostly small page regions, frees mostly aimed at previously allocated addresses
        for (int i = 0; i < 1200; i++) begin
            r = $urandom_range(0, 99);
            if (i == 600)
                drain();
            if (r < 25) begin
                b = $urandom_range(0, 3) == 0 ? rand64()
                    : 64'({$urandom_range(0, 65535), 16'd0});
                seen_addrs.push_back(b);
                send(OP_ADD, b,
                     $urandom_range(0, 7) == 0 ? rand64() : 64'($urandom_range(0, 65535)),
                     52'($urandom()),
                     $urandom_range(0, 2) != 0 ? FREE_KIND : 4'($urandom_range(0, 15)));
            end
            else if (r < 60) begin
                send(OP_ALLOC, rand64(), rand64(),
                     $urandom_range(0, 15) == 0 ? {20'($urandom()), $urandom()}
                                                : 52'($urandom_range(0, 12)),
                     4'($urandom_range(0, 15)));
            end
            else if (r < 98) begin
                send(OP_FREE, pick_free_addr(), rand64(), 52'($urandom()),
                     4'($urandom_range(0, 15)));
            end
            else begin
                send(OP_NONE, rand64(), rand64(), {20'($urandom()), $urandom()},
                     4'($urandom_range(0, 15)));
            end
        end

        drain();
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
